@@ sv/zpmf_pkg.sv @@
// Shared types and constants of the zero-padded median filter.
// No dependencies; imported by zpmf_rank and zero_padded_median_filter.
package zpmf_pkg;

    // Width of the window size register and its value after reset.
    localparam int CFG_WIDTH = 5;
    localparam int WIN_RESET = 5;

    // Rank match of one candidate against the two middle ranks.
    typedef struct packed {
        logic hit_hi;
        logic hit_lo;
    } zpmf_hit_t;

endpackage

@@ sv/zpmf_rank.sv @@
// Shared compare unit: ranks one candidate against every active history lane.
// Depends on zpmf_pkg (zpmf_hit_t).
module zpmf_rank
    import zpmf_pkg::*;
#(
    parameter int MAX_WINDOW   = 16,
    parameter int SAMPLE_WIDTH = 16,
    parameter int CNT_W        = 5
)
(
    input  logic signed [SAMPLE_WIDTH-1:0] hist [MAX_WINDOW],
    input  logic        [MAX_WINDOW-1:0]   lane_en,
    input  logic signed [SAMPLE_WIDTH-1:0] cand,
    input  logic        [CNT_W-1:0]        rank_lo,
    input  logic        [CNT_W-1:0]        rank_hi,
    output zpmf_hit_t                      hit
);

    logic [MAX_WINDOW-1:0] lt_vec;
    logic [MAX_WINDOW-1:0] le_vec;
    logic [CNT_W-1:0]      n_less;
    logic [CNT_W-1:0]      n_leq;

    always_comb
    begin
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            lt_vec[j] = lane_en[j] && (hist[j] < cand);
            le_vec[j] = lane_en[j] && (hist[j] <= cand);
        end
        n_less = CNT_W'($countones(lt_vec));
        n_leq  = CNT_W'($countones(le_vec));
        // The candidate fills sorted positions n_less .. n_leq-1.
        hit.hit_lo = (n_less <= rank_lo) && (rank_lo < n_leq);
        hit.hit_hi = (n_less <= rank_hi) && (rank_hi < n_leq);
    end

endmodule

@@ sv/zero_padded_median_filter.sv @@
// Zero-padded running median filter, top level.
// Depends on zpmf_pkg and zpmf_rank.
//
// Usage:
//   s_* channel takes one word per sample: s_tdata = sample (signed),
//   s_tlast marks the final sample of a sequence. m_* channel returns
//   m_tdata = median_x2 (twice the window median, signed), m_tlast on the
//   final result of the sequence. cfg_we/cfg_data set the window size
//   (0 acts as 1, sizes above MAX_WINDOW act as MAX_WINDOW) and restart the
//   sequence; write it only while the block is idle.
//   Results lag by W/2 samples (odd W) or W/2-1 (even W); the final sample
//   flushes the pending results with zero padding.
//   Each result that a sample causes takes W rank steps of the shared
//   compare unit plus a load into the output register. s_tready is high
//   only while the sequencer is idle, so a new sample is taken only once
//   every result of the last one is loaded; the final one also feeds the
//   zero padding for the results it flushes.
//   If the receiver stalls, the result waits in the output register and the
//   next result holds in the sequencer; nothing is dropped.
//   Reset clears the history and the sample count and sets the window to 5, or to MAX_WINDOW if that is smaller.
module zero_padded_median_filter
    import zpmf_pkg::*;
#(
    parameter int MAX_WINDOW   = 16,
    parameter int SAMPLE_WIDTH = 16,
    localparam int IN_DW       = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW      = ((SAMPLE_WIDTH + 1 + 7) / 8) * 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_DW-1:0]          s_tdata,   // [SAMPLE_WIDTH-1:0] sample
    input  logic                      s_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_DW-1:0]         m_tdata,   // [SAMPLE_WIDTH:0] median_x2
    output logic                      m_tlast,
    input  logic                      cfg_we,
    input  logic [CFG_WIDTH-1:0]      cfg_data
);

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W  = $clog2(MAX_WINDOW);
    localparam int WIN_RST = (WIN_RESET > MAX_WINDOW) ? MAX_WINDOW : WIN_RESET;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_LOAD  = 2'd2;
    localparam logic [1:0] ST_SHIFT = 2'd3;

    logic signed [SAMPLE_WIDTH-1:0] hist_reg [MAX_WINDOW];
    logic [1:0]                     state_reg, state_next;
    logic [CNT_W-1:0]               win_reg, win_next;
    logic [CNT_W-1:0]               seen_reg, seen_next;
    logic [CNT_W-1:0]               t_reg, t_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic                           last_item_reg, last_item_next;
    logic                           res_last_reg, res_last_next;
    logic signed [SAMPLE_WIDTH-1:0] lo_reg, lo_next;
    logic signed [SAMPLE_WIDTH-1:0] hi_reg, hi_next;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH:0]   out_data_reg;
    logic                           out_last_reg;

    logic                           hist_clr;
    logic                           hist_shift;
    logic signed [SAMPLE_WIDTH-1:0] hist_in;
    logic                           load;
    logic                           out_free;
    logic [CNT_W-1:0]               half;
    logic [CNT_W-1:0]               lag;
    logic [CNT_W-1:0]               rank_lo;
    logic [CNT_W-1:0]               seen_inc;
    logic [CNT_W:0]                 flush_pos;
    logic                           idx_last;
    logic [MAX_WINDOW-1:0]          lane_en;
    logic signed [SAMPLE_WIDTH-1:0] cand;
    zpmf_hit_t                      hit;

    assign half     = win_reg >> 1;
    assign lag      = win_reg[0] ? half : half - CNT_W'(1);
    assign rank_lo  = win_reg[0] ? half : half - CNT_W'(1);
    assign seen_inc = (seen_reg < CNT_W'(MAX_WINDOW)) ? seen_reg + CNT_W'(1) : seen_reg;
    assign flush_pos = {1'b0, seen_reg} + {1'b0, t_reg};
    assign idx_last = (CNT_W'(idx_reg) == win_reg - CNT_W'(1));
    assign cand     = hist_reg[idx_reg];
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            lane_en[j] = (j < int'(win_reg));
        end
    end

    zpmf_rank #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .CNT_W        (CNT_W)
    ) u_rank (
        .hist    (hist_reg),
        .lane_en (lane_en),
        .cand    (cand),
        .rank_lo (rank_lo),
        .rank_hi (half),
        .hit     (hit)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        win_next       = win_reg;
        seen_next      = seen_reg;
        t_next         = t_reg;
        idx_next       = idx_reg;
        last_item_next = last_item_reg;
        res_last_next  = res_last_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        hist_clr       = 1'b0;
        hist_shift     = 1'b0;
        hist_in        = '0;
        load           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    hist_shift     = 1'b1;
                    hist_in        = s_tdata[SAMPLE_WIDTH-1:0];
                    seen_next      = seen_inc;
                    last_item_next = s_tlast;
                    t_next         = '0;
                    idx_next       = '0;
                    if (seen_inc > lag)
                    begin
                        state_next    = ST_SCAN;
                        res_last_next = s_tlast && (lag == '0);
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_SHIFT;
                        t_next     = CNT_W'(1);
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit.hit_lo)
                begin
                    lo_next = cand;
                end
                if (hit.hit_hi)
                begin
                    hi_next = cand;
                end
                if (idx_last)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    if (last_item_reg && (t_reg < lag))
                    begin
                        t_next     = t_reg + CNT_W'(1);
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        if (last_item_reg)
                        begin
                            hist_clr  = 1'b1;
                            seen_next = '0;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SHIFT:
            begin
                // Feed one zero of padding past the end of the sequence.
                hist_shift = 1'b1;
                idx_next   = '0;
                if (flush_pos > {1'b0, lag})
                begin
                    state_next    = ST_SCAN;
                    res_last_next = (t_reg == lag);
                end
                else if (t_reg == lag)
                begin
                    hist_clr   = 1'b1;
                    seen_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    t_next = t_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            if (cfg_data == '0)
            begin
                win_next = CNT_W'(1);
            end
            else if (int'(cfg_data) > MAX_WINDOW)
            begin
                win_next = CNT_W'(MAX_WINDOW);
            end
            else
            begin
                win_next = CNT_W'(cfg_data);
            end
            hist_clr  = 1'b1;
            seen_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_reg       <= CNT_W'(WIN_RST);
            seen_reg      <= '0;
            t_reg         <= '0;
            idx_reg       <= '0;
            last_item_reg <= 1'b0;
            res_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            seen_reg      <= seen_next;
            t_reg         <= t_next;
            idx_reg       <= idx_next;
            last_item_reg <= last_item_next;
            res_last_reg  <= res_last_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // History: newest sample in lane 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (hist_clr)
        begin
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (hist_shift)
        begin
            hist_reg[0] <= hist_in;
            for (int i = 1; i < MAX_WINDOW; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (load)
        begin
            out_data_reg <= {lo_reg[SAMPLE_WIDTH-1], lo_reg}
                          + {hi_reg[SAMPLE_WIDTH-1], hi_reg};
            out_last_reg <= res_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        m_tdata                 = '0;
        m_tdata[SAMPLE_WIDTH:0] = out_data_reg;
    end

    a_win_range: assert property (@(posedge clk) disable iff (!rst_n)
        (win_reg != '0) && (win_reg <= CNT_W'(MAX_WINDOW)))
        else $error("window size out of range");

    a_seen_sat: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= CNT_W'(MAX_WINDOW))
        else $error("sample count past saturation");

    a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CNT_W'(idx_reg) < win_reg))
        else $error("rank step beyond window");

    a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && state_next != ST_LOAD) |=> m_tvalid)
        else $error("result left the sequencer but no output word");

endmodule

@@ sim/tb.sv @@
// Testbench for zero_padded_median_filter: streams signed sample sequences under
// random idling on both sides and checks every median word against a local predictor.
// Depends on zpmf_pkg and zero_padded_median_filter.
`timescale 1ns / 100ps

module tb
    import zpmf_pkg::*;
();

    localparam int MAX_WIN    = 16;
    localparam int SW         = 16;
    localparam int IN_DW      = ((SW + 7) / 8) * 8;
    localparam int OUT_DW     = ((SW + 1 + 7) / 8) * 8;
    localparam int IDLE_WAIT  = 200;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 130;

    typedef struct packed {
        logic [OUT_DW-1:0] word;
        logic              lst;
    } median_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_DW-1:0]     s_tdata;    // [15:0] sample
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_DW-1:0]    m_tdata;    // [16:0] median_x2
    logic                 m_tlast;
    logic                 cfg_we;
    logic [CFG_WIDTH-1:0] cfg_data;

    // predictor state
    logic signed [SW-1:0] history [MAX_WIN];
    int                   seq_count;
    int                   win_len;
    median_t              pending_medians [$];

    int   err_cnt;
    int   cycle_cnt;
    bit   no_gaps;
    int   ready_run;

    zero_padded_median_filter #(
        .MAX_WINDOW   (MAX_WIN),
        .SAMPLE_WIDTH (SW)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic void clear_history();
        for (int i = 0; i < MAX_WIN; i++)
            history[i] = '0;
        seq_count = 0;
    endfunction

    function automatic void shift_history(logic signed [SW-1:0] v);
        for (int i = MAX_WIN - 1; i > 0; i--)
            history[i] = history[i-1];
        history[0] = v;
    endfunction

    function automatic logic signed [SW:0] window_median_x2();
        logic signed [SW-1:0] srt [MAX_WIN];
        logic signed [SW-1:0] v;
        logic signed [SW:0]   a;
        logic signed [SW:0]   b;
        int                   j;
        int                   half;
        half = win_len / 2;
        for (int i = 0; i < win_len; i++)
        begin
            v = history[i];
            j = i;
            while (j > 0 && srt[j-1] > v)
            begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = v;
        end
        a = srt[half];
        b = (win_len % 2 == 1) ? srt[half] : srt[half-1];
        return a + b;
    endfunction

    function automatic void push_median(logic signed [SW:0] med, logic lst);
        median_t m;
        m.word = '0;
        m.word[SW:0] = med;
        m.lst = lst;
        pending_medians.push_back(m);
    endfunction

    function automatic void predict_sample(logic signed [SW-1:0] smp, logic lst);
        int lag;
        lag = (win_len % 2 == 1) ? win_len / 2 : win_len / 2 - 1;
        shift_history(smp);
        if (seq_count < MAX_WIN)
            seq_count++;
        if (seq_count > lag)
            push_median(window_median_x2(), lst && lag == 0);
        if (lst)
        begin
            // flush with zero padding past the end
            for (int t = 1; t <= lag; t++)
            begin
                shift_history('0);
                if (seq_count + t > lag)
                    push_median(window_median_x2(), t == lag);
            end
            clear_history();
        end
    endfunction

    // ---------------- idling ----------------

    function automatic int gap_len();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (no_gaps)
        begin
            m_tready <= 1'b1;
            ready_run <= 0;
        end
        else if (ready_run > 0)
            ready_run <= ready_run - 1;
        else if ($urandom_range(0, 3) != 0)
        begin
            m_tready <= 1'b1;
            ready_run <= $urandom_range(0, 8);
        end
        else
        begin
            m_tready <= 1'b0;
            ready_run <= gap_len();
        end
    end

    // ---------------- result check ----------------

    always @(posedge clk)
    begin
        median_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_medians.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected median word, expected none got %0d last %b",
                         $time, $signed(m_tdata[SW:0]), m_tlast);
            end
            else
            begin
                want = pending_medians.pop_front();
                if (m_tdata !== want.word || m_tlast !== want.lst)
                begin
                    err_cnt++;
                    $display("%0t: median_x2 expected %0d (last %b) got %0d (last %b)",
                             $time, $signed(want.word[SW:0]), want.lst,
                             $signed(m_tdata[SW:0]), m_tlast);
                    if (m_tdata[OUT_DW-1:SW+1] !== '0)
                        $display("%0t: pad bits expected 0 got %h", $time,
                                 m_tdata[OUT_DW-1:SW+1]);
                end
            end
        end
    end

    // ---------------- shared tasks ----------------

    task automatic send_sample(input logic signed [SW-1:0] smp, input logic lst);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DW'(smp);
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_sample(smp, lst);
    endtask

    // Hold off the sender until every pending median has come back.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_medians.size() != 0) @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_window_size(input int val);
        int v;
        wait_results_drained();
        cfg_we   <= 1'b1;
        cfg_data <= CFG_WIDTH'(val);
        @(posedge clk);
        cfg_we   <= 1'b0;
        v = val & 31;
        if (v == 0)
            v = 1;
        if (v > MAX_WIN)
            v = MAX_WIN;
        win_len = v;
        clear_history();
    endtask

    function automatic logic signed [SW-1:0] rand_sample(int mode);
        case (mode)
            0: return SW'($urandom);
            1: return SW'($signed($urandom_range(0, 6)) - 3);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 16'sh7fff;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    default: return 16'shffff;
                endcase
            end
            default: return ($urandom_range(0, 1) != 0) ? SW'($urandom)
                                                        : SW'($urandom_range(0, 4));
        endcase
    endfunction

    // ---------------- tests ----------------

    // Default window of 5 after reset, extreme sample values.
    task automatic test_extreme_samples();
        logic signed [SW-1:0] vals [8];
        vals = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff,
                 16'sh0001, 16'sh7fff, 16'sh7fff, 16'sh8000};
        for (int i = 0; i < 8; i++)
            send_sample(vals[i], i == 7);
    endtask

    // Zero, even, maximum, oversize and unit windows; short sequences, below the lag on the two widest windows.
    task automatic test_window_settings();
        int sizes [5];
        int lens  [5];
        sizes = '{0, 2, 16, 31, 1};
        lens  = '{3, 2, 3, 2, 1};
        for (int k = 0; k < 5; k++)
        begin
            write_window_size(sizes[k]);
            for (int i = 0; i < lens[k]; i++)
                send_sample((i % 2 == 0) ? 16'sh8000 : 16'sh7fff, i == lens[k] - 1);
        end
    endtask

    // A register write mid-sequence drops the samples seen so far.
    task automatic test_restart_on_write();
        write_window_size(4);
        send_sample(16'sh1234, 1'b0);
        send_sample(-16'sd77, 1'b0);
        write_window_size(3);
        send_sample(16'sh0100, 1'b0);
        send_sample(16'shff00, 1'b1);
    endtask

    task automatic test_random_sequences();
        int sent;
        int len;
        int mode;
        int cfg_pick [8];
        cfg_pick = '{0, 1, 2, 3, 15, 16, 17, 31};
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                if ($urandom_range(0, 1) != 0)
                    write_window_size(cfg_pick[$urandom_range(0, 7)]);
                else
                    write_window_size($urandom_range(0, 31));
            end
            else if ($urandom_range(0, 5) == 0)
                wait_results_drained();
            no_gaps = ($urandom_range(0, 3) == 0);
            mode = $urandom_range(0, 3);
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
            for (int i = 0; i < len; i++)
                send_sample(rand_sample(mode), i == len - 1);
            sent += len;
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_data <= '0;
        m_tready <= 1'b0;
        ready_run = 0;
        no_gaps   = 1'b0;
        err_cnt   = 0;
        cycle_cnt = 0;
        win_len   = WIN_RESET;
        clear_history();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extreme_samples();
        test_window_settings();
        test_restart_on_write();
        test_random_sequences();
        wait_results_drained();

        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
sv/zpmf_pkg.sv
sv/zpmf_rank.sv
sv/zero_padded_median_filter.sv
sim/tb.sv
